FILE: sv/lcs_pkg.sv
package lcs_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int WORD_W  = 48;
    localparam int SLOT_W  = 5;
    localparam int LAYER_W = 4;
    localparam int CODE_W  = 12;
    localparam int LEDS_PER_BYTE = 4;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Grayscale code for each 2-bit LED level
    localparam logic [CODE_W-1:0] LEVEL_CODE [LEDS_PER_BYTE] = '{
        12'h000, 12'h2BC, 12'h5D0, 12'hFFF
    };

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  serial_word;
        logic [SLOT_W-1:0]  byte_slot;
        logic [LAYER_W-1:0] layer_now;
        logic               row_restart;
        logic               last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic store_write;
        logic tick_start;
        logic read_step;
    } lcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic slot_last;
        logic out_free;
    } lcs_stat_t;

    // Expand one frame byte into four codes, MSB pair in the top code
    function automatic logic [WORD_W-1:0] pack_byte(input logic [DATA_W-1:0] b);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int k = 0; k < LEDS_PER_BYTE; k++)
        begin
            word[WORD_W-1-CODE_W*k -: CODE_W] = LEVEL_CODE[b[DATA_W-1-2*k -: 2]];
        end
        return word;
    endfunction

endpackage

FILE: sv/led_cube_layer_scan_serializer.sv
// Layer-scan serializer for a multiplexed LED cube.
//
// Input channel (in_valid / in_ready / in_item): a write item stores one
// frame byte at its address (addresses past the store are dropped) and
// gives no result; one write is taken per cycle while idle. A tick item
// advances the layer counter (wrapping after the last layer) and reads that
// layer's bytes, giving one result per byte on the output channel
// (out_valid / out_ready / out_item). The final result of a tick has last
// set, and row_restart set when the layer is 0.
// Scan: a taken tick moves the controller to its scan state, which issues
// reads from the single frame store read port into the output register;
// results follow one a cycle while the output is not stalled. A tick holds
// in_ready low until all its reads are issued, before the next item is taken.
// Reset: the store is cleared by a sweep over all LAYER_COUNT * BYTES_PER_LAYER
// bytes (250 at the defaults), one byte a cycle, with in_ready low.
// Stall: the result waits in the output register; the scan pauses until it
// is taken, and the next item is still taken once all reads are issued.
module led_cube_layer_scan_serializer #(
    parameter int LAYER_COUNT     = 10,
    parameter int BYTES_PER_LAYER = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output lcs_pkg::out_item_t out_item
);
    import lcs_pkg::*;

    lcs_cmd_t  cmd;
    lcs_stat_t stat;

    lcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_item.operation),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lcs_datapath #(
        .LAYER_COUNT     (LAYER_COUNT),
        .BYTES_PER_LAYER (BYTES_PER_LAYER)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: sv/lcs_ctrl.sv
module lcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              operation,
    output logic              in_ready,
    input  lcs_pkg::lcs_stat_t stat,
    output lcs_pkg::lcs_cmd_t  cmd
);
    import lcs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_SCAN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequence clearing, idle and layer scan
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.store_write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue a read only when the output stage can take it
                cmd.read_step = stat.out_free;
                if (stat.out_free && stat.slot_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/lcs_datapath.sv
module lcs_datapath #(
    parameter int LAYER_COUNT     = 10,
    parameter int BYTES_PER_LAYER = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lcs_pkg::lcs_cmd_t  cmd,
    input  lcs_pkg::in_item_t  in_item,
    output lcs_pkg::lcs_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output lcs_pkg::out_item_t out_item
);
    import lcs_pkg::*;

    localparam int STORE_SIZE = LAYER_COUNT * BYTES_PER_LAYER;
    localparam int AW  = $clog2(STORE_SIZE);
    localparam int AXW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int SW  = (BYTES_PER_LAYER > 1) ? $clog2(BYTES_PER_LAYER) : 1;
    localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;

    logic [7:0]         frame_mem [STORE_SIZE];

    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      base_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [SW-1:0]      slot_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  rdata_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [LAYER_W-1:0] layer_out_reg;
    logic               last_out_reg;
    logic               row_restart_out_reg;

    logic [AXW-1:0]     wr_addr_x;
    logic               wr_in_range;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [AW-1:0]      rd_addr;
    logic               layer_wrap;
    logic [SXW-1:0]     slot_x;

    // Status towards the controller
    assign stat.clear_last = (clr_addr_reg == AW'(STORE_SIZE - 1));
    assign stat.slot_last  = (slot_reg == SW'(BYTES_PER_LAYER - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Select the single write port: clearing pass or frame write
    assign wr_addr_x   = AXW'(in_item.address);
    assign wr_in_range = (wr_addr_x < AXW'(STORE_SIZE));
    assign mem_we      = cmd.clear_step || (cmd.store_write && wr_in_range);
    assign mem_waddr   = cmd.clear_step ? clr_addr_reg : wr_addr_x[AW-1:0];
    assign mem_wdata   = cmd.clear_step ? '0 : in_item.data;

    assign rd_addr    = base_reg + AW'(slot_reg);
    assign layer_wrap = (layer_reg == LAYER_W'(LAYER_COUNT - 1));
    assign slot_x     = SXW'(slot_reg);

    // Frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_step)
        begin
            rdata_reg <= frame_mem[rd_addr];
        end
    end

    // Clear sweep, layer and slot counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            base_reg     <= '0;
            layer_reg    <= '0;
            slot_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.tick_start)
            begin
                slot_reg <= '0;
                if (layer_wrap)
                begin
                    layer_reg <= '0;
                    base_reg  <= '0;
                end
                else
                begin
                    layer_reg <= layer_reg + LAYER_W'(1);
                    base_reg  <= base_reg + AW'(BYTES_PER_LAYER);
                end
            end
            else if (cmd.read_step)
            begin
                slot_reg <= stat.slot_last ? '0 : slot_reg + SW'(1);
            end
        end
    end

    // Output stage valid: load on read, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.read_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the tags of the byte in flight
    always_ff @(posedge clk)
    begin
        if (cmd.read_step)
        begin
            slot_out_reg        <= slot_x[SLOT_W-1:0];
            layer_out_reg       <= layer_reg;
            last_out_reg        <= stat.slot_last;
            row_restart_out_reg <= stat.slot_last && (layer_reg == '0);
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_item.serial_word = pack_byte(rdata_reg);
    assign out_item.byte_slot   = slot_out_reg;
    assign out_item.layer_now   = layer_out_reg;
    assign out_item.row_restart = row_restart_out_reg;
    assign out_item.last        = last_out_reg;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import lcs_pkg::*;

    localparam int LAYERS         = 10;
    localparam int SLOTS          = 25;
    localparam int STORE_BYTES    = LAYERS * SLOTS;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 30;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Mirror of the frame store and layer counter
    logic [DATA_W-1:0]  frame_copy [STORE_BYTES];
    logic [LAYER_W-1:0] scan_layer;
    out_item_t          due_words [$];

    bit gaps_on = 1'b1;
    int mismatches = 0;
    int quiet_cycles = 0;

    led_cube_layer_scan_serializer #(
        .LAYER_COUNT     (LAYERS),
        .BYTES_PER_LAYER (SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expand one frame byte into four grayscale codes, MSB pair on top
    function automatic logic [WORD_W-1:0] grey_word(input logic [DATA_W-1:0] b);
        logic [WORD_W-1:0] w;
        logic [CODE_W-1:0] code;
        w = '0;
        for (int k = 0; k < 4; k++)
        begin
            case (b[DATA_W-1-2*k -: 2])
                2'd0:    code = 12'h000;
                2'd1:    code = 12'h2BC;
                2'd2:    code = 12'h5D0;
                default: code = 12'hFFF;
            endcase
            w = {w[WORD_W-CODE_W-1:0], code};
        end
        return w;
    endfunction

    // Apply one accepted item to the mirror; a tick queues a whole layer
    task automatic advance_scan(input in_item_t it);
        out_item_t r;
        int        idx;
        if (it.operation == OP_WRITE)
        begin
            if (it.address < STORE_BYTES)
                frame_copy[it.address] = it.data;
        end
        else
        begin
            scan_layer = (scan_layer == LAYERS - 1) ? '0 : scan_layer + 1'b1;
            for (int s = 0; s < SLOTS; s++)
            begin
                idx           = scan_layer * SLOTS + s;
                r.serial_word = grey_word(frame_copy[idx]);
                r.byte_slot   = s[SLOT_W-1:0];
                r.layer_now   = scan_layer;
                r.last        = (s == SLOTS - 1);
                r.row_restart = r.last && (scan_layer == 0);
                due_words.push_back(r);
            end
        end
    endtask

    // Compare one result against the oldest expectation
    task automatic check_word(input out_item_t want, input out_item_t got);
        if (got.serial_word !== want.serial_word)
        begin
            $error("serial_word: expected %h, got %h", want.serial_word, got.serial_word);
            mismatches++;
        end
        if (got.byte_slot !== want.byte_slot)
        begin
            $error("byte_slot: expected %0d, got %0d", want.byte_slot, got.byte_slot);
            mismatches++;
        end
        if (got.layer_now !== want.layer_now)
        begin
            $error("layer_now: expected %0d, got %0d", want.layer_now, got.layer_now);
            mismatches++;
        end
        if (got.row_restart !== want.row_restart)
        begin
            $error("row_restart: expected %b, got %b", want.row_restart, got.row_restart);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %b, got %b", want.last, got.last);
            mismatches++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
            frame_copy[i] = '0;
        scan_layer = '0;
    end

    // Track accepted input items
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            advance_scan(in_item);
    end

    // Check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_words.size() == 0)
            begin
                $error("unexpected result: %p", out_item);
                mismatches++;
            end
            else
                check_word(due_words.pop_front(), out_item);
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Abort when nothing moves for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        in_item_t it;
        it.operation = op;
        it.address   = addr;
        it.data      = data;
        if (gaps_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold the sender until every queued result has come out
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    // Send random items; only ticks and in-range writes are counted
    task automatic send_random(input int n);
        int counted;
        int pick;
        logic [ADDR_W-1:0] addr;
        counted = 0;
        while (counted < n)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                send_item(OP_TICK, ADDR_W'($urandom_range(255)),
                          DATA_W'($urandom_range(255)));
                counted++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    addr = ADDR_W'($urandom_range(255, STORE_BYTES));
                else
                    addr = ADDR_W'($urandom_range(STORE_BYTES - 1));
                send_item(OP_WRITE, addr, DATA_W'($urandom_range(255)));
                if (addr < STORE_BYTES)
                    counted++;
            end
        end
    endtask

    // First tick after reset drives layer 1 from a cleared store
    task automatic test_cleared_store;
        send_item(OP_TICK, 8'h00, 8'h00);
    endtask

    // Writes at the store ends, past the end, and data extremes
    task automatic test_write_edges;
        send_item(OP_WRITE, 8'd0, 8'hE4);
        send_item(OP_WRITE, 8'd24, 8'hFF);
        send_item(OP_WRITE, 8'd25, 8'h1B);
        send_item(OP_WRITE, 8'd26, 8'hFF);
        send_item(OP_WRITE, 8'd26, 8'h00);
        send_item(OP_WRITE, 8'd249, 8'hFF);
        send_item(OP_WRITE, 8'd250, 8'hAA);
        send_item(OP_WRITE, 8'd255, 8'h55);
    endtask

    // Tick through every layer, past the wrap to layer 0 and on to layer 1
    task automatic test_layer_wrap;
        for (int i = 0; i < LAYERS; i++)
            send_item(OP_TICK, 8'hFF, 8'hFF);
    endtask

    task automatic test_random_traffic;
        send_random(200);
    endtask

    // No idling on either side
    task automatic test_unbroken_burst;
        gaps_on = 1'b0;
        send_random(80);
        gaps_on = 1'b1;
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drained_pauses;
        for (int i = 0; i < 5; i++)
        begin
            send_random(10);
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_store();
        test_write_edges();
        test_layer_wrap();
        test_random_traffic();
        test_unbroken_burst();
        test_drained_pauses();

        // Drain and let the block settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (due_words.size() != 0)
        begin
            $error("%0d results never arrived", due_words.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
